FILE: rtl/kmdl_pkg.sv
// ----------------------------------------------------------------------------
// kmdl_pkg
// Shared types and constants for the key matrix debounce and layer event block.
// ----------------------------------------------------------------------------
package kmdl_pkg;

    localparam int KEY_BITS            = 48;
    localparam int LAYERS              = 4;
    localparam int ROWS_DEFAULT        = 4;
    localparam int COLS_DEFAULT        = 12;
    localparam int QUEUE_DEPTH_DEFAULT = 4;
    localparam int CFG_IDX_W           = 3;
    localparam int CFG_DATA_W          = 48;

    localparam logic [7:0] DEBOUNCE_RESET = 8'd6;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAYER_ONE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAYER_TWO    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LAYER_THREE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPECIAL_BASE = 3'd4;

    // input item kinds
    localparam logic REQ_SCAN  = 1'b0;
    localparam logic REQ_TABLE = 1'b1;

    // event kinds
    localparam logic [3:0] EV_PRESS       = 4'd0;
    localparam logic [3:0] EV_RELEASE     = 4'd1;
    localparam logic [3:0] EV_RELEASE_ALL = 4'd2;
    localparam logic [3:0] EV_LIGHT_BASE  = 4'd3;

    typedef struct packed {
        logic [7:0]          debounce_ms;
        logic [KEY_BITS-1:0] layer_one_mask;
        logic [KEY_BITS-1:0] layer_two_mask;
        logic [KEY_BITS-1:0] layer_three_mask;
        logic [7:0]          special_base;
    } t_cfg;

    // command from the front end to the event walker
    typedef struct packed {
        logic                is_write;
        logic                release_all;
        logic [1:0]          layer;
        logic [5:0]          key;
        logic [7:0]          code;
        logic [KEY_BITS-1:0] diff;
        logic [KEY_BITS-1:0] stable;
    } t_cmd;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] code;
        logic [5:0] index;
        logic       last;
    } t_event;

endpackage

FILE: rtl/key_matrix_debounce_layer_events.sv
// ----------------------------------------------------------------------------
// key_matrix_debounce_layer_events
// Key matrix debounce with layer selection and key event generation.
// ----------------------------------------------------------------------------
// The slave stream takes scan samples and layout table writes (tuser selects
// which); the master stream delivers press, release, release-all and lighting
// events, with tlast on the final event of a sample. The front end queues a
// table write to a key within the matrix and a sample that changes the
// debounced state; the event walker then applies a table write and, for a
// sample, steps through each key position (min(ROWS*COLS, 48)), reading the
// layout table for each changed key, and finally flushes the held event. The
// walk stalls while the output register is full and not taken. After reset,
// the layout table is cleared at one entry per cycle, 4*ROWS*COLS entries
// (192 by default); no item is accepted during that pass, while configuration
// writes are taken as ever.
// ----------------------------------------------------------------------------
module key_matrix_debounce_layer_events
    import kmdl_pkg::*;
#(
    parameter int ROWS        = ROWS_DEFAULT,
    parameter int COLS        = COLS_DEFAULT,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: now_ms[31:0], key_bits[79:32], table_layer[81:80],
    //        table_key[87:82], table_code[95:88]
    input  logic [95:0]           s_axis_tdata,
    // tuser: req_type[0]
    input  logic                  s_axis_tuser,
    // event stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: keycode[7:0], key_index[13:8], zero fill[15:14]
    output logic [15:0]           m_axis_tdata,
    // tuser: event_kind[3:0]
    output logic [3:0]            m_axis_tuser,
    // tlast: last_event
    output logic                  m_axis_tlast
);

    t_cfg   r_cfg;
    t_cmd   w_push_cmd;
    t_cmd   w_pop_cmd;
    logic   w_push;
    logic   w_full;
    logic   w_pop;
    logic   w_cmd_valid;
    logic   w_clearing;
    t_event w_event;

    // Register writes; software must change these only while the block is idle, which the block does not enforce.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms      <= DEBOUNCE_RESET;
            r_cfg.layer_one_mask   <= '0;
            r_cfg.layer_two_mask   <= '0;
            r_cfg.layer_three_mask <= '0;
            r_cfg.special_base     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEBOUNCE:     r_cfg.debounce_ms      <= i_cfg_data[7:0];
                CFG_LAYER_ONE:    r_cfg.layer_one_mask   <= i_cfg_data[KEY_BITS-1:0];
                CFG_LAYER_TWO:    r_cfg.layer_two_mask   <= i_cfg_data[KEY_BITS-1:0];
                CFG_LAYER_THREE:  r_cfg.layer_three_mask <= i_cfg_data[KEY_BITS-1:0];
                CFG_SPECIAL_BASE: r_cfg.special_base     <= i_cfg_data[7:0];
                default: begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    // Front end: debounce, pick the layer and classify each transaction.
    kmdl_front #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_req_type    (s_axis_tuser),
        .i_now_ms      (s_axis_tdata[31:0]),
        .i_key_bits    (s_axis_tdata[79:32]),
        .i_table_layer (s_axis_tdata[81:80]),
        .i_table_key   (s_axis_tdata[87:82]),
        .i_table_code  (s_axis_tdata[95:88]),
        .i_full        (w_full),
        .i_clearing    (w_clearing),
        .o_push        (w_push),
        .o_cmd         (w_push_cmd)
    );

    // Queue: lets the front keep taking samples while a walk is running.
    kmdl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_cmd_valid),
        .o_data  (w_pop_cmd)
    );

    // Back end: apply table writes in order with walks, emit events.
    kmdl_back #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_special_base (r_cfg.special_base),
        .i_cmd_valid    (w_cmd_valid),
        .i_cmd          (w_pop_cmd),
        .o_cmd_pop      (w_pop),
        .o_clearing     (w_clearing),
        .o_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .o_out          (w_event)
    );

    assign m_axis_tdata = {2'b00, w_event.index, w_event.code};
    assign m_axis_tuser = w_event.kind;
    assign m_axis_tlast = w_event.last;

endmodule

FILE: rtl/kmdl_queue.sv
// ----------------------------------------------------------------------------
// kmdl_queue
// Small command queue between the sample front end and the event walker.
// ----------------------------------------------------------------------------
module kmdl_queue
    import kmdl_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_count;

    logic w_push;
    logic w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

FILE: rtl/kmdl_front.sv
// ----------------------------------------------------------------------------
// kmdl_front
// Accepts scan samples and table writes, debounces, selects the layer.
// ----------------------------------------------------------------------------
module kmdl_front
    import kmdl_pkg::*;
#(
    parameter int ROWS = ROWS_DEFAULT,
    parameter int COLS = COLS_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_req_type,
    input  logic [31:0]         i_now_ms,
    input  logic [KEY_BITS-1:0] i_key_bits,
    input  logic [1:0]          i_table_layer,
    input  logic [5:0]          i_table_key,
    input  logic [7:0]          i_table_code,
    input  logic                i_full,
    input  logic                i_clearing,
    output logic                o_push,
    output t_cmd                o_cmd
);

    localparam int KEYS  = ROWS * COLS;
    localparam int NWALK = (KEYS < KEY_BITS) ? KEYS : KEY_BITS;
    localparam logic [KEY_BITS-1:0] WALK_MASK =
        (NWALK == KEY_BITS) ? {KEY_BITS{1'b1}} :
                              ((KEY_BITS'(1) << NWALK) - KEY_BITS'(1));

    // stable equals the last reported state after every settle
    logic [KEY_BITS-1:0] r_raw_prev;
    logic [31:0]         r_start;
    logic [KEY_BITS-1:0] r_stable;
    logic [1:0]          r_layer;

    logic        w_accept;
    logic [31:0] n_start;
    logic [31:0] w_elapsed;
    logic        w_settle;
    logic        w_changed;
    logic [1:0]  n_layer;

    assign o_ready   = !i_full && !i_clearing;
    assign w_accept  = i_valid && o_ready;
    assign n_start   = (i_key_bits != r_raw_prev) ? i_now_ms : r_start;
    assign w_elapsed = i_now_ms - n_start;
    assign w_settle  = w_elapsed > {24'd0, i_cfg.debounce_ms};
    assign w_changed = r_stable != i_key_bits;

    always_comb begin
        if ((i_key_bits & i_cfg.layer_one_mask) != '0) begin
            n_layer = 2'd1;
        end else if ((i_key_bits & i_cfg.layer_two_mask) != '0) begin
            n_layer = 2'd2;
        end else if ((i_key_bits & i_cfg.layer_three_mask) != '0) begin
            n_layer = 2'd3;
        end else begin
            n_layer = 2'd0;
        end
    end

    always_comb begin
        o_cmd.is_write    = (i_req_type == REQ_TABLE);
        o_cmd.release_all = (n_layer != r_layer);
        o_cmd.layer       = (i_req_type == REQ_TABLE) ? i_table_layer : n_layer;
        o_cmd.key         = i_table_key;
        o_cmd.code        = i_table_code;
        o_cmd.diff        = (i_key_bits ^ r_stable) & WALK_MASK;
        o_cmd.stable      = i_key_bits;
        if (i_req_type == REQ_TABLE) begin
            // drop writes to keys beyond the matrix
            o_push = w_accept && (int'(i_table_key) < KEYS);
        end else begin
            o_push = w_accept && w_settle && w_changed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_prev <= '0;
            r_start    <= '0;
            r_stable   <= '0;
            r_layer    <= '0;
        end else if (w_accept && (i_req_type == REQ_SCAN)) begin
            r_raw_prev <= i_key_bits;
            r_start    <= n_start;
            if (w_settle && w_changed) begin
                r_stable <= i_key_bits;
                r_layer  <= n_layer;
            end
        end
    end

endmodule

FILE: rtl/kmdl_back.sv
// ----------------------------------------------------------------------------
// kmdl_back
// Owns the layout table; walks changed keys and emits events.
// ----------------------------------------------------------------------------
module kmdl_back
    import kmdl_pkg::*;
#(
    parameter int ROWS = ROWS_DEFAULT,
    parameter int COLS = COLS_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_special_base,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_cmd_pop,
    output logic       o_clearing,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_event     o_out
);

    localparam int KEYS  = ROWS * COLS;
    localparam int NWALK = (KEYS < KEY_BITS) ? KEYS : KEY_BITS;
    localparam int DEPTH = LAYERS * KEYS;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] KEYS_A = AW'(KEYS);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_EVAL,
        ST_FLUSH
    } t_state;

    t_state              r_state;
    logic [AW-1:0]       r_clr;
    logic [5:0]          r_k;
    logic [1:0]          r_layer;
    logic [KEY_BITS-1:0] r_diff;
    logic [KEY_BITS-1:0] r_stable;
    logic                r_pend_v;
    t_event              r_pend;
    logic                r_out_v;
    t_event              r_out;
    logic [7:0]          r_rd_data;
    logic [7:0]          r_mem [DEPTH];

    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [7:0]    w_wdata;
    logic          w_re;
    logic [AW-1:0] w_raddr;
    logic          w_out_free;
    logic          w_at_end;
    logic          w_load;

    logic [8:0] w_code9;
    logic [8:0] w_base9;
    logic [8:0] w_top9;
    logic       w_light;
    logic       w_high;
    logic       w_pressed;
    logic       w_hit;
    t_event     w_ev;
    logic [2:0] w_light_ofs;

    assign o_clearing  = (r_state == ST_CLEAR);
    assign o_out_valid = r_out_v;
    assign o_out       = r_out;
    assign o_cmd_pop   = (r_state == ST_IDLE) && i_cmd_valid;
    assign w_out_free  = !r_out_v || i_out_ready;
    assign w_at_end    = (r_k == 6'(NWALK));
    // the held event moves to the output register this cycle
    assign w_load      = w_out_free && r_pend_v &&
                         (((r_state == ST_EVAL) && w_hit) || (r_state == ST_FLUSH));

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_clr;
        w_wdata = '0;
        w_re    = 1'b0;
        w_raddr = AW'(r_layer) * KEYS_A + AW'(r_k);
        case (r_state)
            ST_CLEAR: begin
                w_we = 1'b1;
            end
            ST_IDLE: begin
                w_we    = i_cmd_valid && i_cmd.is_write;
                w_waddr = AW'(i_cmd.layer) * KEYS_A + AW'(i_cmd.key);
                w_wdata = i_cmd.code;
            end
            ST_SCAN: begin
                w_re = !w_at_end && r_diff[r_k];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd_data <= r_mem[w_raddr];
        end
    end

    // classify the table code of the key under evaluation
    always_comb begin
        w_code9     = {1'b0, r_rd_data};
        w_base9     = {1'b0, i_special_base};
        w_top9      = w_base9 + 9'd7;
        w_light     = (w_code9 >= w_base9) && (w_code9 <= w_top9);
        w_high      = w_code9 > w_top9;
        w_pressed   = r_stable[r_k];
        w_hit       = w_pressed ? (w_light || w_high) : w_high;
        w_light_ofs = r_rd_data[2:0] - i_special_base[2:0];
        w_ev.code   = r_rd_data;
        w_ev.index  = r_k;
        w_ev.last   = 1'b0;
        if (!w_pressed) begin
            w_ev.kind = EV_RELEASE;
        end else if (w_light) begin
            w_ev.kind = EV_LIGHT_BASE + {1'b0, w_light_ofs};
        end else begin
            w_ev.kind = EV_PRESS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_k      <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_v <= 1'b1;
            end else if (r_out_v && i_out_ready) begin
                r_out_v <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(DEPTH - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_cmd_valid && !i_cmd.is_write) begin
                        r_diff   <= i_cmd.diff;
                        r_stable <= i_cmd.stable;
                        r_layer  <= i_cmd.layer;
                        r_k      <= '0;
                        if (i_cmd.release_all) begin
                            r_pend_v     <= 1'b1;
                            r_pend.kind  <= EV_RELEASE_ALL;
                            r_pend.code  <= '0;
                            r_pend.index <= '0;
                            r_pend.last  <= 1'b0;
                        end
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (w_at_end) begin
                        r_state <= ST_FLUSH;
                    end else if (r_diff[r_k]) begin
                        r_state <= ST_EVAL;
                    end else begin
                        r_k <= r_k + 6'd1;
                    end
                end
                ST_EVAL: begin
                    // hold one event back so the final one can carry last
                    if (!w_hit) begin
                        r_k     <= r_k + 6'd1;
                        r_state <= ST_SCAN;
                    end else if (!r_pend_v) begin
                        r_pend   <= w_ev;
                        r_pend_v <= 1'b1;
                        r_k      <= r_k + 6'd1;
                        r_state  <= ST_SCAN;
                    end else if (w_out_free) begin
                        r_out   <= r_pend;
                        r_pend  <= w_ev;
                        r_k     <= r_k + 6'd1;
                        r_state <= ST_SCAN;
                    end
                end
                ST_FLUSH: begin
                    if (!r_pend_v) begin
                        r_state <= ST_IDLE;
                    end else if (w_out_free) begin
                        r_out    <= '{kind: r_pend.kind, code: r_pend.code,
                                      index: r_pend.index, last: 1'b1};
                        r_pend_v <= 1'b0;
                        r_state  <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    a_no_event_while_clearing : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !r_out_v)
        else $error("event presented during table clearing");

    a_walk_in_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k <= 6'(NWALK))
        else $error("key walk ran past the last key");

    a_eval_on_changed_key : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EVAL) |-> r_diff[r_k])
        else $error("table lookup on a key that did not change");

    a_idle_nothing_held : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend_v)
        else $error("held event left behind at end of walk");

endmodule
